@@ rtl/bsfr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the byte-stuffed frame receiver.
// Used by bsfr_step and byte_stuffed_frame_receiver_core; depends on nothing.
package bsfr_pkg;

    // Largest payload per frame; two more body bytes form the check word.
    localparam int MAX_PAYLOAD = 1024;
    localparam int BODY_LIMIT  = MAX_PAYLOAD + 2;
    localparam int CNT_W       = $clog2(BODY_LIMIT + 1);

    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int CHK_W  = 16;
    localparam int LEN_W  = 11;

    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h1b;
    localparam logic [BYTE_W-1:0] FLAG_RESET = 8'd126;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_FLAG = 1'b0;   // paddr[2] selects the register

    // Result kinds.
    localparam logic [KIND_W-1:0] K_SEQ     = 3'd0;
    localparam logic [KIND_W-1:0] K_PAYLOAD = 3'd1;
    localparam logic [KIND_W-1:0] K_END     = 3'd2;
    localparam logic [KIND_W-1:0] K_TRUNC   = 3'd3;
    localparam logic [KIND_W-1:0] K_NOFLAG  = 3'd4;
    localparam logic [KIND_W-1:0] K_SHORT   = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_SEQ  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_DROP = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic                esc;
        logic [CNT_W-1:0]    cnt;
        logic [BYTE_W-1:0]   older;
        logic [BYTE_W-1:0]   newer;
    } t_state;

    typedef struct packed {
        logic                valid;
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   value;
        logic [CHK_W-1:0]    check_word;
        logic [LEN_W-1:0]    payload_length;
    } t_result;

endpackage

@@ rtl/byte_stuffed_frame_receiver_core.sv @@
`timescale 1ns / 1ps
// Top level of the byte-stuffed frame receiver: input register, deframer state,
// result register and the APB register port. Depends on bsfr_pkg and bsfr_step.
//
//   channel   direction  handshake               payload
//   input     in         i_in_valid/o_in_stall   i_rx_byte
//   result    out        o_out_valid/i_out_stall o_kind, o_value, o_check_word,
//                                                o_payload_length
//   config    in         APB psel/penable/pready paddr, pwdata, prdata
//
// One item per cycle while the result register is not stalled: a byte enters the input
// register, is decoded from it and any result is loaded into the result register.
// A result is visible once it is loaded into the result register and is taken at an
// edge where i_out_stall is low.
// A stalled result register backs up into the input register and then o_in_stall.
// Synchronous active-low reset returns the deframer to idle with flag 126.
module byte_stuffed_frame_receiver_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [bsfr_pkg::BYTE_W-1:0]          i_rx_byte,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [bsfr_pkg::KIND_W-1:0]          o_kind,
    output logic [bsfr_pkg::BYTE_W-1:0]          o_value,
    output logic [bsfr_pkg::CHK_W-1:0]           o_check_word,
    output logic [bsfr_pkg::LEN_W-1:0]           o_payload_length,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bsfr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bsfr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bsfr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic                          r_in_valid;
    logic [bsfr_pkg::BYTE_W-1:0]   r_in_byte;
    logic [bsfr_pkg::BYTE_W-1:0]   r_flag;
    bsfr_pkg::t_state              r_st;
    bsfr_pkg::t_state              n_st;
    bsfr_pkg::t_result             step_res;
    bsfr_pkg::t_result             r_res;
    logic                          out_free;
    logic                          proc_fire;
    logic                          in_accept;
    logic                          cfg_wr;

    assign out_free   = !r_res.valid || !i_out_stall;
    assign proc_fire  = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !proc_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    bsfr_step u_step (
        .i_state  (r_st),
        .i_byte   (r_in_byte),
        .i_flag   (r_flag),
        .o_state  (n_st),
        .o_result (step_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Deframer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase <= bsfr_pkg::PH_IDLE;
            r_st.esc   <= 1'b0;
            r_st.cnt   <= '0;
            r_st.older <= '0;
            r_st.newer <= '0;
        end else if (proc_fire) begin
            r_st <= n_st;
        end
    end

    // Result register; only the valid bit is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (proc_fire && step_res.valid) begin
            r_res <= step_res;
        end else if (!i_out_stall) begin
            r_res.valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_res.valid;
    assign o_kind           = r_res.kind;
    assign o_value          = r_res.value;
    assign o_check_word     = r_res.check_word;
    assign o_payload_length = r_res.payload_length;

    // APB register port; the flag register is the only one.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == bsfr_pkg::REG_IDX_FLAG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= bsfr_pkg::FLAG_RESET;
        end else if (cfg_wr) begin
            r_flag <= pwdata[bsfr_pkg::BYTE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == bsfr_pkg::REG_IDX_FLAG) begin
            prdata[bsfr_pkg::BYTE_W-1:0] = r_flag;
        end
    end

    // The body counter never runs past the limit.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.cnt <= bsfr_pkg::CNT_W'(bsfr_pkg::BODY_LIMIT))
        else $error("body count beyond limit");

    // An escape can only be pending inside a frame.
    a_esc_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.esc |-> (r_st.phase == bsfr_pkg::PH_BODY || r_st.phase == bsfr_pkg::PH_DROP))
        else $error("escape pending outside a frame");

    // A sequence result always opens the body phase.
    a_seq_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && step_res.valid && step_res.kind == bsfr_pkg::K_SEQ)
        |=> (r_st.phase == bsfr_pkg::PH_BODY && r_st.cnt == '0))
        else $error("sequence result without entering body");

    // A held input item is neither lost nor changed while the result side is busy.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc_fire) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input item lost");

endmodule

@@ rtl/bsfr_step.sv @@
`timescale 1ns / 1ps
// Next-state and result logic of the deframer for one received byte.
// Purely combinational; uses types and constants from bsfr_pkg.
module bsfr_step (
    input  bsfr_pkg::t_state                  i_state,
    input  logic [bsfr_pkg::BYTE_W-1:0]       i_byte,
    input  logic [bsfr_pkg::BYTE_W-1:0]       i_flag,
    output bsfr_pkg::t_state                  o_state,
    output bsfr_pkg::t_result                 o_result
);

    always_comb begin
        logic                              literal;
        logic                              do_finish;
        logic [bsfr_pkg::KIND_W-1:0]       fin_kind;
        logic                              at_limit;

        o_state   = i_state;
        o_result  = '0;
        literal   = 1'b0;
        do_finish = 1'b0;
        fin_kind  = bsfr_pkg::K_END;
        at_limit  = (i_state.cnt >= bsfr_pkg::CNT_W'(bsfr_pkg::BODY_LIMIT));

        unique case (i_state.phase)
            bsfr_pkg::PH_IDLE: begin
                if (i_byte == i_flag) begin
                    o_state.phase = bsfr_pkg::PH_SEQ;
                end else begin
                    o_result.valid = 1'b1;
                    o_result.kind  = bsfr_pkg::K_NOFLAG;
                end
            end
            bsfr_pkg::PH_SEQ: begin
                // The sequence byte is taken raw, even if it matches flag or escape.
                o_state.phase  = bsfr_pkg::PH_BODY;
                o_state.esc    = 1'b0;
                o_state.cnt    = '0;
                o_state.older  = '0;
                o_state.newer  = '0;
                o_result.valid = 1'b1;
                o_result.kind  = bsfr_pkg::K_SEQ;
                o_result.value = i_byte;
            end
            bsfr_pkg::PH_BODY: begin
                if (i_state.esc) begin
                    o_state.esc = 1'b0;
                    literal     = 1'b1;
                end else if (i_byte == bsfr_pkg::ESC_BYTE) begin
                    o_state.esc = 1'b1;
                    if (at_limit) begin
                        o_state.phase = bsfr_pkg::PH_DROP;
                    end
                end else if (i_byte == i_flag) begin
                    do_finish = 1'b1;
                    fin_kind  = bsfr_pkg::K_END;
                end else begin
                    literal = 1'b1;
                end
                if (literal) begin
                    if (at_limit) begin
                        o_state.phase = bsfr_pkg::PH_DROP;
                    end else begin
                        // Bytes are held back by two so the last pair becomes the check word.
                        if (i_state.cnt >= bsfr_pkg::CNT_W'(2)) begin
                            o_result.valid = 1'b1;
                            o_result.kind  = bsfr_pkg::K_PAYLOAD;
                            o_result.value = i_state.older;
                        end
                        o_state.older = i_state.newer;
                        o_state.newer = i_byte;
                        o_state.cnt   = i_state.cnt + bsfr_pkg::CNT_W'(1);
                    end
                end
            end
            bsfr_pkg::PH_DROP: begin
                if (i_state.esc) begin
                    o_state.esc = 1'b0;
                end else if (i_byte == bsfr_pkg::ESC_BYTE) begin
                    o_state.esc = 1'b1;
                end else if (i_byte == i_flag) begin
                    do_finish = 1'b1;
                    fin_kind  = bsfr_pkg::K_TRUNC;
                end
            end
            default: begin
                o_state.phase = bsfr_pkg::PH_IDLE;
                o_state.esc   = 1'b0;
            end
        endcase

        if (do_finish) begin
            o_state.phase  = bsfr_pkg::PH_IDLE;
            o_state.esc    = 1'b0;
            o_result.valid = 1'b1;
            if (i_state.cnt < bsfr_pkg::CNT_W'(2)) begin
                o_result.kind = bsfr_pkg::K_SHORT;
            end else begin
                o_result.kind           = fin_kind;
                o_result.check_word     = {i_state.newer, i_state.older};
                o_result.payload_length =
                    bsfr_pkg::LEN_W'(i_state.cnt - bsfr_pkg::CNT_W'(2));
            end
        end
    end

endmodule
